[sv/bbrt_pkg.sv]
// Shared types and constants for the bad-block remap table.
// Used by bbrt_ctrl, bbrt_datapath and flash_bad_block_remap_table.
`timescale 1ns / 1ps

package bbrt_pkg;

  localparam int MAX_PAIRS   = 64;
  localparam int BLOCK_PAGES = 64;  // power of two

  localparam int PAGE_W  = 22;
  localparam int BLOCK_W = 16;
  localparam int OFF_W   = $clog2(BLOCK_PAGES);
  localparam int IDX_W   = $clog2(MAX_PAIRS);
  localparam int CNT_W   = $clog2(MAX_PAIRS + 1);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SELF_MAP = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_CHAIN    = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    accept;        // take the input request
    logic    scan;          // issue the next table read
    logic    hop;           // follow the matched replacement, restart scan
    logic    finish;        // latch finish_status
    status_e finish_status;
    logic    load_out;      // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;      // table holds MAX_PAIRS entries
    logic hit;       // registered entry matches current block
    logic miss;      // scan ended without a match
    logic hops_max;  // MAX_PAIRS hops taken already
    logic self_map;  // matched entry maps page onto itself
  } sts_t;

endpackage

[sv/flash_bad_block_remap_table.sv]
// Top level of the NAND bad-block remap table.
// Instantiates bbrt_ctrl and bbrt_datapath; uses bbrt_pkg.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------
//   in      | in_valid_i / in_ready_o | operation_i, page_address_i,
//           |                         | bad_block_i, replacement_block_i
//   out     | out_valid_o/out_ready_i | physical_page_o, status_o
//   cfg     | cfg_we_i (no wait)      | cfg_wdata_i -> remap_enable
//
// Flow: an add, or a lookup with remapping off, goes from accept straight to
//   ST_DONE and then to the output register. A lookup walks the pair memory
//   one entry a cycle through its single read port, restarting on every hop.
// Reset: asynchronous, active low; the table empties, remap_enable sets.
// Stalls: a new request is taken while a result waits at the output; a
//   finished request then holds in the controller until the output frees.

`timescale 1ns / 1ps

module flash_bad_block_remap_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [bbrt_pkg::PAGE_W-1:0]   page_address_i,
  input  logic [bbrt_pkg::BLOCK_W-1:0]  bad_block_i,
  input  logic [bbrt_pkg::BLOCK_W-1:0]  replacement_block_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbrt_pkg::PAGE_W-1:0]   physical_page_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i
);

  bbrt_pkg::cmd_t dp_cmd;
  bbrt_pkg::sts_t dp_sts;

  // sequencing: accept, scan, hop decisions, output handoff
  bbrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // table memory, page walk and result registers
  bbrt_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .sts_o               (dp_sts),
    .operation_i         (operation_i),
    .page_address_i      (page_address_i),
    .bad_block_i         (bad_block_i),
    .replacement_block_i (replacement_block_i),
    .physical_page_o     (physical_page_o),
    .status_o            (status_o)
  );

`ifndef SYNTH
  // a request never completes in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready_o high right after an accepted request");

  // the table only grows, so full never clears
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(dp_sts.full))
    else $error("table full flag dropped without reset");

  // a scan step cannot both match and end empty-handed
  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_sts.hit && dp_sts.miss))
    else $error("hit and miss both set");

  // the datapath only loads the output when the output slot is free
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.load_out && out_valid_o) |-> out_ready_i)
    else $error("output overwritten while still pending");
`endif

endmodule

[sv/bbrt_datapath.sv]
// Datapath of the remap table: pair memory, entry count, scan pointer,
// current page, hop counter and result registers. Uses bbrt_pkg.
`timescale 1ns / 1ps

module bbrt_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bbrt_pkg::cmd_t                 cmd_i,
  output bbrt_pkg::sts_t                 sts_o,
  input  logic                           operation_i,
  input  logic [bbrt_pkg::PAGE_W-1:0]    page_address_i,
  input  logic [bbrt_pkg::BLOCK_W-1:0]   bad_block_i,
  input  logic [bbrt_pkg::BLOCK_W-1:0]   replacement_block_i,
  output logic [bbrt_pkg::PAGE_W-1:0]    physical_page_o,
  output logic [1:0]                     status_o
);

  // pair memory: {bad, replacement}
  logic [2*bbrt_pkg::BLOCK_W-1:0] mem_q [bbrt_pkg::MAX_PAIRS];
  logic [2*bbrt_pkg::BLOCK_W-1:0] rd_data_q;

  logic [bbrt_pkg::CNT_W-1:0]  count_q, count_d;
  logic [bbrt_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic                        pend_q, pend_d;
  logic [bbrt_pkg::CNT_W-1:0]  hops_q, hops_d;
  logic [bbrt_pkg::PAGE_W-1:0] cur_q;
  bbrt_pkg::status_e           res_status_q;
  logic [bbrt_pkg::PAGE_W-1:0] out_page_q;
  bbrt_pkg::status_e           out_status_q;

  logic [bbrt_pkg::BLOCK_W-1:0] rd_bad, rd_repl;
  logic [bbrt_pkg::PAGE_W-1:0]  nxt_page;
  logic                         is_add, full, rd_en, wr_en;

  assign rd_bad  = rd_data_q[2*bbrt_pkg::BLOCK_W-1:bbrt_pkg::BLOCK_W];
  assign rd_repl = rd_data_q[bbrt_pkg::BLOCK_W-1:0];
  assign nxt_page = bbrt_pkg::PAGE_W'((32'(rd_repl) << bbrt_pkg::OFF_W)
                                      | 32'(cur_q[bbrt_pkg::OFF_W-1:0]));

  assign is_add = (operation_i == bbrt_pkg::OP_ADD);
  assign full   = (count_q >= bbrt_pkg::CNT_W'(bbrt_pkg::MAX_PAIRS));
  assign wr_en  = cmd_i.accept && is_add && !full;
  assign rd_en  = cmd_i.scan && (idx_q < count_q);

  assign sts_o.full     = full;
  assign sts_o.hit      = pend_q && (32'(rd_bad) == 32'(cur_q >> bbrt_pkg::OFF_W));
  assign sts_o.miss     = !pend_q && (idx_q >= count_q);
  assign sts_o.hops_max = (hops_q >= bbrt_pkg::CNT_W'(bbrt_pkg::MAX_PAIRS));
  assign sts_o.self_map = (nxt_page == cur_q);

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    hops_d  = hops_q;
    if (wr_en) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.accept) begin
      idx_d  = '0;
      pend_d = 1'b0;
      hops_d = '0;
    end else if (cmd_i.hop) begin
      idx_d  = '0;
      pend_d = 1'b0;
      hops_d = hops_q + 1'b1;
    end else if (cmd_i.scan) begin
      pend_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      hops_q  <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      hops_q  <= hops_d;
    end
  end

  // memory and payload registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[bbrt_pkg::IDX_W-1:0]] <= {bad_block_i, replacement_block_i};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[bbrt_pkg::IDX_W-1:0]];
    end
    if (cmd_i.accept) begin
      cur_q        <= is_add ? '0 : page_address_i;
      res_status_q <= (is_add && full) ? bbrt_pkg::STAT_FULL : bbrt_pkg::STAT_OK;
    end else if (cmd_i.hop) begin
      cur_q <= nxt_page;
    end
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.finish_status;
    end
    if (cmd_i.load_out) begin
      out_page_q   <= cur_q;
      out_status_q <= res_status_q;
    end
  end

  assign physical_page_o = out_page_q;
  assign status_o        = out_status_q;

endmodule

[sv/bbrt_ctrl.sv]
// Controller of the remap table: request sequencing, hop decisions,
// output valid and the remap enable register. Uses bbrt_pkg.
`timescale 1ns / 1ps

module bbrt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           operation_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  bbrt_pkg::sts_t sts_i,
  output bbrt_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   enable_q, enable_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    enable_d    = cfg_we_i ? cfg_wdata_i : enable_q;
    cmd_o       = '0;
    cmd_o.finish_status = bbrt_pkg::STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (operation_i == bbrt_pkg::OP_ADD || !enable_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          if (sts_i.hops_max) begin
            cmd_o.finish        = 1'b1;
            cmd_o.finish_status = bbrt_pkg::STAT_CHAIN;
            state_d             = ST_DONE;
          end else if (sts_i.self_map) begin
            cmd_o.finish        = 1'b1;
            cmd_o.finish_status = bbrt_pkg::STAT_SELF_MAP;
            state_d             = ST_DONE;
          end else begin
            cmd_o.hop = 1'b1;
          end
        end else if (sts_i.miss) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      enable_q    <= enable_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sim/tb_flash_bad_block_remap_table.sv]
// Self-checking testbench for flash_bad_block_remap_table: directed table, then random phases.
// A shadow remap table predicts each response not typed into a directed row, and results are compared in order.
// Depends on bbrt_pkg and the flash_bad_block_remap_table RTL.
`timescale 1ns / 1ps

module tb_flash_bad_block_remap_table;
  import bbrt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  // Slowest lookup: 64 hops, each a walk of the full table.
  // The watchdog limit is set well above the expected run.
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int TAIL_CYCLES  = 40;
  localparam int CFG_SETTLE   = 4;
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;
  localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;

  typedef struct packed {
    op_e                op;
    logic [PAGE_W-1:0]  page;
    logic [BLOCK_W-1:0] bad;
    logic [BLOCK_W-1:0] repl;
  } remap_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    status_e           status;
  } remap_res_t;

  // typed = 1: the response is written into the row; else the shadow table decides
  typedef struct packed {
    logic       enable;
    remap_req_t req;
    logic       typed;
    remap_res_t res;
  } directed_row_t;

  typedef struct packed {
    logic        enable;
    int unsigned send_idle;
    int unsigned recv_stall;
    int unsigned items;
  } phase_t;

  localparam remap_res_t NO_RES = '{page: '0, status: STAT_OK};

  localparam int NUM_DIRECTED = 23;
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    // empty table: pages pass through, both extremes
    '{1'b1, '{OP_LOOKUP, 22'd0, 16'h0000, 16'h0000}, 1'b1, '{22'd0, STAT_OK}},
    '{1'b1, '{OP_LOOKUP, PAGE_MAX, BLOCK_MAX, BLOCK_MAX}, 1'b1, '{PAGE_MAX, STAT_OK}},
    // block 0 -> block 0xFFFF; add answers with page zero
    '{1'b1, '{OP_ADD, 22'h2AAAAA, 16'h0000, BLOCK_MAX}, 1'b1, '{22'd0, STAT_OK}},
    '{1'b1, '{OP_LOOKUP, 22'd5, 16'h1234, 16'h4321}, 1'b1, '{22'h3FFFC5, STAT_OK}},
    // top block mapped onto itself
    '{1'b1, '{OP_ADD, 22'h155555, BLOCK_MAX, BLOCK_MAX}, 1'b1, '{22'd0, STAT_OK}},
    '{1'b1, '{OP_LOOKUP, PAGE_MAX, 16'h0000, 16'h0000}, 1'b1, '{PAGE_MAX, STAT_SELF_MAP}},
    // one hop, then a self map at the end of the chain
    '{1'b1, '{OP_LOOKUP, 22'd1, 16'h0000, 16'h0000}, 1'b0, NO_RES},
    // two-link chain 100 -> 200 -> 300
    '{1'b1, '{OP_ADD, 22'd0, 16'd100, 16'd200}, 1'b0, NO_RES},
    '{1'b1, '{OP_ADD, 22'd0, 16'd200, 16'd300}, 1'b0, NO_RES},
    '{1'b1, '{OP_LOOKUP, {16'd100, 6'd7}, 16'h0000, 16'h0000}, 1'b0, NO_RES},
    // loop 500 <-> 501: walk runs out of hops
    '{1'b1, '{OP_ADD, 22'd0, 16'd500, 16'd501}, 1'b0, NO_RES},
    '{1'b1, '{OP_ADD, 22'd0, 16'd501, 16'd500}, 1'b0, NO_RES},
    '{1'b1, '{OP_LOOKUP, {16'd500, 6'd0}, 16'h0000, 16'h0000}, 1'b0, NO_RES},
    // duplicate bad block: the first entry keeps winning
    '{1'b1, '{OP_ADD, 22'd0, 16'd100, 16'd999}, 1'b0, NO_RES},
    '{1'b1, '{OP_LOOKUP, {16'd100, 6'd63}, 16'h0000, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, '{OP_ADD, PAGE_MAX, 16'h5555, 16'hAAAA}, 1'b0, NO_RES},
    '{1'b1, '{OP_ADD, 22'd0, 16'hAAAA, 16'h1234}, 1'b0, NO_RES},
    '{1'b1, '{OP_LOOKUP, {16'h5555, 6'd42}, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RES},
    // remapping off: lookups pass through, adds still land in the table
    '{1'b0, '{OP_LOOKUP, 22'd5, 16'h0000, 16'h0000}, 1'b1, '{22'd5, STAT_OK}},
    '{1'b0, '{OP_ADD, 22'd0, 16'd1, 16'd2}, 1'b1, '{22'd0, STAT_OK}},
    '{1'b0, '{OP_LOOKUP, {16'd500, 6'd0}, 16'h0000, 16'h0000}, 1'b1, '{22'd32000, STAT_OK}},
    // back on: the pair added while off is live
    '{1'b1, '{OP_LOOKUP, {16'd1, 6'd3}, 16'h0000, 16'h0000}, 1'b0, NO_RES},
    '{1'b1, '{OP_LOOKUP, 22'h155555, 16'h0000, 16'h0000}, 1'b0, NO_RES}
  };

  // enable, sender idle %, receiver stall %, requests
  localparam int NUM_PHASES = 4;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{1'b1, 0,  0,  400},
    '{1'b0, 55, 0,  200},
    '{1'b1, 0,  55, 400},
    '{1'b1, 20, 20, 400}
  };

  logic                 clk_i;
  logic                 rst_ni              = 1'b0;
  logic                 in_valid_i          = 1'b0;
  logic                 in_ready_o;
  logic                 operation_i         = 1'b0;
  logic [PAGE_W-1:0]    page_address_i      = '0;
  logic [BLOCK_W-1:0]   bad_block_i         = '0;
  logic [BLOCK_W-1:0]   replacement_block_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i         = 1'b0;
  logic [PAGE_W-1:0]    physical_page_o;
  logic [1:0]           status_o;
  logic                 cfg_we_i            = 1'b0;
  logic                 cfg_wdata_i         = 1'b0;

  // Shadow copy of the pair table and the enable register
  logic [BLOCK_W-1:0]   shadow_bad  [MAX_PAIRS];
  logic [BLOCK_W-1:0]   shadow_repl [MAX_PAIRS];
  int                   shadow_count  = 0;
  logic                 shadow_enable = 1'b1;

  remap_res_t           pending_results [$];
  int unsigned          stall_pct = 0;
  int unsigned          err_count = 0;

  flash_bad_block_remap_table u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .operation_i         (operation_i),
    .page_address_i      (page_address_i),
    .bad_block_i         (bad_block_i),
    .replacement_block_i (replacement_block_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .physical_page_o     (physical_page_o),
    .status_o            (status_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Apply one request to the shadow table and return the expected response.
  // Adds append or report full; lookups pass through with remapping off, else
  // follow the chain until a miss, a self map, or a hit after MAX_PAIRS hops.
  function automatic remap_res_t translate_request(remap_req_t r);
    remap_res_t        res;
    logic [PAGE_W-1:0] cur;
    logic [PAGE_W-1:0] nxt;
    int unsigned       blk;
    int unsigned       off;
    int                hit;
    int                hops;
    int                i;
    res = NO_RES;
    if (r.op == OP_ADD) begin
      if (shadow_count >= MAX_PAIRS) begin
        res.status = STAT_FULL;
      end else begin
        shadow_bad[shadow_count]  = r.bad;
        shadow_repl[shadow_count] = r.repl;
        shadow_count++;
      end
      return res;
    end
    cur = r.page;
    if (!shadow_enable) begin
      res.page = cur;
      return res;
    end
    for (hops = 0; hops <= MAX_PAIRS; hops++) begin
      blk = cur / BLOCK_PAGES;
      off = cur % BLOCK_PAGES;
      hit = -1;
      // scan downward so the lowest matching index is left in hit
      for (i = shadow_count - 1; i >= 0; i--) begin
        if (shadow_bad[i] == blk) hit = i;
      end
      res.page = cur;
      if (hit < 0) return res;
      if (hops == MAX_PAIRS) begin
        res.status = STAT_CHAIN;
        return res;
      end
      nxt = PAGE_W'(shadow_repl[hit] * BLOCK_PAGES + off);
      if (nxt == cur) begin
        res.status = STAT_SELF_MAP;
        return res;
      end
      cur = nxt;
    end
    return res;
  endfunction

  // Mostly random block numbers, with the two extremes mixed in
  function automatic logic [BLOCK_W-1:0] any_block();
    case ($urandom_range(9))
      0: return '0;
      1: return BLOCK_MAX;
      default: return BLOCK_W'($urandom);
    endcase
  endfunction

  // Random request shaped to build chains, loops and self maps in the table,
  // and to aim most lookups at blocks the table actually holds.
  function automatic remap_req_t random_request();
    remap_req_t  r;
    int unsigned pick;
    int unsigned k;
    r.op   = OP_LOOKUP;
    r.page = PAGE_W'($urandom);
    r.bad  = BLOCK_W'($urandom);
    r.repl = BLOCK_W'($urandom);
    k    = (shadow_count > 0) ? $urandom_range(shadow_count - 1) : 0;
    pick = $urandom_range(99);
    if ($urandom_range(99) < ((shadow_count < MAX_PAIRS) ? 40 : 15)) begin
      r.op = OP_ADD;
      if (shadow_count == 0 || pick < 45) begin
        r.bad  = any_block();
        r.repl = any_block();
      end else if (pick < 75) begin
        // extend an existing chain
        r.bad  = shadow_repl[k];
        r.repl = any_block();
      end else if (pick < 85) begin
        r.repl = r.bad;
      end else if (pick < 87) begin
        // close a loop; kept rare, every lookup into it costs a full walk
        r.bad  = shadow_repl[k];
        r.repl = shadow_bad[k];
      end else begin
        // shadowed duplicate
        r.bad  = shadow_bad[k];
        r.repl = any_block();
      end
    end else if (shadow_count > 0 && pick < 45) begin
      r.page = PAGE_W'(shadow_bad[k] * BLOCK_PAGES + $urandom_range(BLOCK_PAGES - 1));
    end else if (shadow_count > 0 && pick < 55) begin
      r.page = PAGE_W'(shadow_repl[k] * BLOCK_PAGES + $urandom_range(BLOCK_PAGES - 1));
    end else if (pick < 65) begin
      r.page = $urandom_range(1) ? PAGE_MAX : '0;
    end
    return r;
  endfunction

  // Drive one request with random idle cycles ahead of it, wait for the
  // handshake, then record the expected response. Valid is left high so a
  // following request can go back to back.
  task automatic send_request(remap_req_t r, int unsigned idle_pct, logic typed,
                              remap_res_t typed_res);
    remap_res_t got;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    operation_i         <= r.op;
    page_address_i      <= r.page;
    bad_block_i         <= r.bad;
    replacement_block_i <= r.repl;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    got = translate_request(r);
    pending_results.push_back(typed ? typed_res : got);
  endtask

  // Config is only written with nothing in flight
  task automatic write_remap_enable(logic value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= value;
    shadow_enable = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver back-pressure, one draw per cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every delivered response against the oldest expectation
  always @(posedge clk_i) begin : response_check
    remap_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("response with none pending: physical_page %0d status %0d",
               physical_page_o, status_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (physical_page_o !== want.page) begin
          $error("physical_page: expected %0d, got %0d", want.page, physical_page_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    int p;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; enable changes happen between rows while idle
    write_remap_enable(1'b1);
    for (n = 0; n < NUM_DIRECTED; n++) begin
      if (DIRECTED[n].enable != shadow_enable) write_remap_enable(DIRECTED[n].enable);
      send_request(DIRECTED[n].req, 0, DIRECTED[n].typed, DIRECTED[n].res);
    end

    // Random phases with different idle and stall mixes
    for (p = 0; p < NUM_PHASES; p++) begin
      write_remap_enable(PHASES[p].enable);
      stall_pct = PHASES[p].recv_stall;
      for (n = 0; n < PHASES[p].items; n++) begin
        send_request(random_request(), PHASES[p].send_idle, 1'b0, NO_RES);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_flash_bad_block_remap_table: clean");
    end else begin
      $display("tb_flash_bad_block_remap_table: errors");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_flash_bad_block_remap_table: errors");
    $finish;
  end

endmodule
